### sv/assert_macros.svh
// assertion macros shared by the bounding box rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AM_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define AM_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/pcbb_pkg.sv
// package: constants, codes and types of the point cloud bounding box unit
package pcbb_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int NUM_AXES        = 3;
    localparam int IN_WIDTH        = 32;
    localparam int OUT_WIDTH       = 32;
    localparam int HALF_WIDTH      = 31;
    localparam int SQ_WIDTH        = 2 * HALF_WIDTH;
    localparam int SUM_WIDTH       = 64;
    localparam int ROOT_STEPS      = SUM_WIDTH / 2;
    localparam int CNT_WIDTH       = $clog2(ROOT_STEPS);

    localparam logic [SUM_WIDTH-1:0]  MIN_HALF = SUM_WIDTH'(1311);
    localparam logic [SUM_WIDTH-1:0]  HALF_MAX = SUM_WIDTH'(32'h7fff_ffff);

    localparam logic CMD_ACCUM  = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SQUARE,
        BK_ROOT,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

### sv/pcbb_front.sv
// front end: accepts items, saturates coordinates, tracks running min and max
module pcbb_front
    import pcbb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic signed [IN_WIDTH-1:0]    coord_x,
    input  logic signed [IN_WIDTH-1:0]    coord_y,
    input  logic signed [IN_WIDTH-1:0]    coord_z,
    input  logic                          is_finite,
    input  qstat_t                        stat,
    output logic                          push,
    output logic [6*COORD_WIDTH:0]        snap
);

    localparam logic signed [63:0] C_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] C_MIN = -C_MAX - 64'sd1;

    logic signed [COORD_WIDTH-1:0] min_reg  [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] min_next [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] max_reg  [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] max_next [NUM_AXES];
    logic                          seen_reg;
    logic                          seen_next;
    logic signed [IN_WIDTH-1:0]    raw      [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] sat      [NUM_AXES];
    logic signed [63:0]            ext      [NUM_AXES];
    logic                          accept;

    assign busy   = stat.full;
    assign accept = start && !stat.full;
    assign push   = accept && (cmd == CMD_FINISH);

    assign raw[0] = coord_x;
    assign raw[1] = coord_y;
    assign raw[2] = coord_z;

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            ext[a] = 64'(raw[a]);
            if (ext[a] > C_MAX)
            begin
                sat[a] = COORD_WIDTH'(C_MAX);
            end
            else if (ext[a] < C_MIN)
            begin
                sat[a] = COORD_WIDTH'(C_MIN);
            end
            else
            begin
                sat[a] = COORD_WIDTH'(ext[a]);
            end
        end
    end

    always_comb
    begin
        seen_next = seen_reg;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            min_next[a] = min_reg[a];
            max_next[a] = max_reg[a];
        end
        if (push)
        begin
            seen_next = 1'b0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                min_next[a] = COORD_WIDTH'(C_MAX);
                max_next[a] = COORD_WIDTH'(C_MIN);
            end
        end
        else if (accept && is_finite)
        begin
            seen_next = 1'b1;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                if (sat[a] < min_reg[a])
                begin
                    min_next[a] = sat[a];
                end
                if (sat[a] > max_reg[a])
                begin
                    max_next[a] = sat[a];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                min_reg[a] <= COORD_WIDTH'(C_MAX);
                max_reg[a] <= COORD_WIDTH'(C_MIN);
            end
        end
        else
        begin
            seen_reg <= seen_next;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                min_reg[a] <= min_next[a];
                max_reg[a] <= max_next[a];
            end
        end
    end

    assign snap = {seen_reg, max_reg[2], max_reg[1], max_reg[0],
                   min_reg[2], min_reg[1], min_reg[0]};

endmodule

### sv/pcbb_queue.sv
// short queue of finished box snapshots between front and back
module pcbb_queue
    import pcbb_pkg::*;
#(
    parameter int DATA_WIDTH = 6 * COORD_WIDTH_DEF + 1,
    parameter int DEPTH      = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  pop,
    output logic [DATA_WIDTH-1:0] rd_data,
    output qstat_t                stat
);

    `include "assert_macros.svh"

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `AM_IMPL(a_no_overflow, clk, rst_n, push, !stat.full, "push into full queue")
    `AM_IMPL(a_no_underflow, clk, rst_n, pop, !stat.empty, "pop from empty queue")

endmodule

### sv/pcbb_back.sv
// back end: half extents, squared sum, bit-serial square root and result beats
module pcbb_back
    import pcbb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [6*COORD_WIDTH:0]        snap,
    input  qstat_t                        stat,
    output logic                          pop,
    output logic                          result_strobe,
    output logic [1:0]                    axis,
    output logic signed [OUT_WIDTH-1:0]   low_bound,
    output logic signed [OUT_WIDTH-1:0]   high_bound,
    output logic signed [OUT_WIDTH-1:0]   mid_point,
    output logic [HALF_WIDTH-1:0]         half_extent,
    output logic [OUT_WIDTH-1:0]          radius,
    output logic                          bounds_valid,
    output logic                          last
);

    `include "assert_macros.svh"

    back_state_t state_reg;
    back_state_t state_next;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic [CNT_WIDTH-1:0] cnt_next;

    logic signed [COORD_WIDTH-1:0] lo_reg   [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] lo_next  [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] hi_reg   [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] hi_next  [NUM_AXES];
    logic [HALF_WIDTH-1:0]         half_reg [NUM_AXES];
    logic [HALF_WIDTH-1:0]         half_next[NUM_AXES];
    logic                          seen_reg;
    logic                          seen_next;
    logic [SQ_WIDTH-1:0]           prod_reg;
    logic [SQ_WIDTH-1:0]           prod_next;
    logic [SUM_WIDTH-1:0]          sum_reg;
    logic [SUM_WIDTH-1:0]          sum_next;
    logic [SUM_WIDTH-1:0]          res_reg;
    logic [SUM_WIDTH-1:0]          res_next;

    logic signed [COORD_WIDTH-1:0] lo_in    [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] hi_in    [NUM_AXES];
    logic signed [COORD_WIDTH:0]   diff     [NUM_AXES];
    logic [COORD_WIDTH-1:0]        half_raw [NUM_AXES];
    logic [SUM_WIDTH-1:0]          half_ext [NUM_AXES];
    logic [HALF_WIDTH-1:0]         half_in  [NUM_AXES];
    logic [HALF_WIDTH-1:0]         sq_sel;
    logic [SUM_WIDTH-1:0]          root_bit;
    logic [SUM_WIDTH-1:0]          trial;
    logic [1:0]                    ax;
    logic signed [COORD_WIDTH:0]   mid_sum;
    logic signed [COORD_WIDTH-1:0] mid_val;
    logic [OUT_WIDTH-1:0]          rad_val;

    // snapshot unpack and half extent per axis
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            lo_in[a]    = snap[a * COORD_WIDTH +: COORD_WIDTH];
            hi_in[a]    = snap[(NUM_AXES + a) * COORD_WIDTH +: COORD_WIDTH];
            diff[a]     = (COORD_WIDTH + 1)'(hi_in[a]) - (COORD_WIDTH + 1)'(lo_in[a]);
            half_raw[a] = diff[a][COORD_WIDTH:1];
            half_ext[a] = SUM_WIDTH'(half_raw[a]);
            if (half_ext[a] < MIN_HALF)
            begin
                half_in[a] = HALF_WIDTH'(MIN_HALF);
            end
            else if (half_ext[a] > HALF_MAX)
            begin
                half_in[a] = HALF_WIDTH'(HALF_MAX);
            end
            else
            begin
                half_in[a] = half_ext[a][HALF_WIDTH-1:0];
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!stat.empty)
                begin
                    state_next = snap[6 * COORD_WIDTH] ? BK_SQUARE : BK_EMIT;
                end
            end
            BK_SQUARE:
            begin
                if (cnt_reg == CNT_WIDTH'(NUM_AXES))
                begin
                    state_next = BK_ROOT;
                end
            end
            BK_ROOT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (cnt_reg == CNT_WIDTH'(NUM_AXES - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // datapath
    assign sq_sel   = (cnt_reg < CNT_WIDTH'(NUM_AXES)) ? half_reg[cnt_reg[1:0]] : '0;
    assign root_bit = SUM_WIDTH'(1) << {cnt_reg, 1'b0};
    assign trial    = res_reg + root_bit;

    always_comb
    begin
        cnt_next  = cnt_reg;
        seen_next = seen_reg;
        prod_next = prod_reg;
        sum_next  = sum_reg;
        res_next  = res_reg;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            lo_next[a]   = lo_reg[a];
            hi_next[a]   = hi_reg[a];
            half_next[a] = half_reg[a];
        end
        unique case (state_reg)
            BK_IDLE:
            begin
                cnt_next  = '0;
                prod_next = '0;
                sum_next  = '0;
                res_next  = '0;
                if (!stat.empty)
                begin
                    seen_next = snap[6 * COORD_WIDTH];
                    for (int a = 0; a < NUM_AXES; a++)
                    begin
                        lo_next[a]   = lo_in[a];
                        hi_next[a]   = hi_in[a];
                        half_next[a] = half_in[a];
                    end
                end
            end
            BK_SQUARE:
            begin
                prod_next = SQ_WIDTH'(sq_sel) * SQ_WIDTH'(sq_sel);
                sum_next  = sum_reg + SUM_WIDTH'(prod_reg);
                cnt_next  = (cnt_reg == CNT_WIDTH'(NUM_AXES)) ?
                            CNT_WIDTH'(ROOT_STEPS - 1) : cnt_reg + 1'b1;
            end
            BK_ROOT:
            begin
                if (sum_reg >= trial)
                begin
                    sum_next = sum_reg - trial;
                    res_next = (res_reg >> 1) + root_bit;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                cnt_next = (cnt_reg == '0) ? '0 : cnt_reg - 1'b1;
            end
            BK_EMIT:
            begin
                cnt_next = (cnt_reg == CNT_WIDTH'(NUM_AXES - 1)) ? '0 : cnt_reg + 1'b1;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // outputs
    assign ax      = cnt_reg[1:0];
    assign mid_sum = (COORD_WIDTH + 1)'(lo_reg[ax]) + (COORD_WIDTH + 1)'(hi_reg[ax]);
    assign mid_val = mid_sum[COORD_WIDTH:1];
    assign rad_val = (res_reg < MIN_HALF) ? OUT_WIDTH'(MIN_HALF) : res_reg[OUT_WIDTH-1:0];

    always_comb
    begin
        pop           = 1'b0;
        result_strobe = 1'b0;
        axis          = ax;
        low_bound     = '0;
        high_bound    = '0;
        mid_point     = '0;
        half_extent   = '0;
        radius        = '0;
        bounds_valid  = 1'b0;
        last          = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop = !stat.empty;
            end
            BK_SQUARE, BK_ROOT:
            begin
                pop = 1'b0;
            end
            BK_EMIT:
            begin
                result_strobe = 1'b1;
                last          = (ax == AXIS_Z);
                if (seen_reg)
                begin
                    low_bound    = OUT_WIDTH'(lo_reg[ax]);
                    high_bound   = OUT_WIDTH'(hi_reg[ax]);
                    mid_point    = OUT_WIDTH'(mid_val);
                    half_extent  = half_reg[ax];
                    radius       = rad_val;
                    bounds_valid = 1'b1;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seen_reg <= seen_next;
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        res_reg  <= res_next;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            lo_reg[a]   <= lo_next[a];
            hi_reg[a]   <= hi_next[a];
            half_reg[a] <= half_next[a];
        end
    end

    `AM_IMPL(a_strobe_in_emit, clk, rst_n, result_strobe, state_reg == BK_EMIT, "beat outside emit")
    `AM_IMPL(a_last_on_z, clk, rst_n, last, result_strobe && axis == AXIS_Z, "last off z beat")

endmodule

### sv/point_cloud_bounding_box_unit.sv
// point cloud bounding box unit: top level joining front, queue and back
// accumulate item: one point per cycle while busy is low, no result
// finish item: x beat follows the squaring steps and the bit-serial root steps,
// then y and z beats on the following cycles; an empty set skips straight to its beats
// busy is high while the snapshot queue is full; the back takes a new box only when idle
// reset clears accumulators, queue pointers and back state; results are not stalled
module point_cloud_bounding_box_unit
    import pcbb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic signed [IN_WIDTH-1:0]    coord_x,
    input  logic signed [IN_WIDTH-1:0]    coord_y,
    input  logic signed [IN_WIDTH-1:0]    coord_z,
    input  logic                          is_finite,
    output logic                          result_strobe,
    output logic [1:0]                    axis,
    output logic signed [OUT_WIDTH-1:0]   low_bound,
    output logic signed [OUT_WIDTH-1:0]   high_bound,
    output logic signed [OUT_WIDTH-1:0]   mid_point,
    output logic [HALF_WIDTH-1:0]         half_extent,
    output logic [OUT_WIDTH-1:0]          radius,
    output logic                          bounds_valid,
    output logic                          last
);

    localparam int SNAP_W = 6 * COORD_WIDTH + 1;

    qstat_t            stat;
    logic              push;
    logic              pop;
    logic [SNAP_W-1:0] wr_snap;
    logic [SNAP_W-1:0] rd_snap;

    pcbb_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .is_finite (is_finite),
        .stat      (stat),
        .push      (push),
        .snap      (wr_snap)
    );

    pcbb_queue #(
        .DATA_WIDTH (SNAP_W),
        .DEPTH      (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_snap),
        .pop     (pop),
        .rd_data (rd_snap),
        .stat    (stat)
    );

    pcbb_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .snap          (rd_snap),
        .stat          (stat),
        .pop           (pop),
        .result_strobe (result_strobe),
        .axis          (axis),
        .low_bound     (low_bound),
        .high_bound    (high_bound),
        .mid_point     (mid_point),
        .half_extent   (half_extent),
        .radius        (radius),
        .bounds_valid  (bounds_valid),
        .last          (last)
    );

endmodule
